/* hw/rtl/rgb_conv3x3_zero_pad_assert.svh */
// assertion macros for the rgb 3x3 convolution block checkers
// expects i_clk and i_rst_n in the scope of each use
`ifndef RGB_CONV3X3_ZERO_PAD_ASSERT_SVH
`define RGB_CONV3X3_ZERO_PAD_ASSERT_SVH

// property checked outside reset only
`define RCZ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define RCZ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/rcz_pkg.sv */
// shared types, constants and register codes of the rgb 3x3 convolution block
// no dependencies
`default_nettype none

package rcz_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_COEF_BITS  = 16;

    localparam int PIX_BITS      = 8;
    localparam int NUM_CH        = 3;
    localparam int RGB_BITS      = PIX_BITS * NUM_CH;
    localparam int KERN_DIM      = 3;
    localparam int NUM_TAPS      = KERN_DIM * KERN_DIM;
    localparam int FRAC_BITS     = 8;
    localparam int PIX_MAX       = 255;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DIM_BITS  = 12;
    localparam int CFG_KERN_BITS = 48;

    localparam int MIN_WIDTH     = 2;
    localparam int MIN_HEIGHT    = 1;
    localparam int WIDTH_RST     = 640;
    localparam int HEIGHT_RST    = 480;
    localparam logic [CFG_KERN_BITS-1:0] KERN_TOP_RST = 48'd0;
    localparam logic [CFG_KERN_BITS-1:0] KERN_MID_RST = 48'd256;
    localparam logic [CFG_KERN_BITS-1:0] KERN_BOT_RST = 48'd0;

    localparam int QUEUE_DEPTH   = 2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_KERN_TOP = 3'd2,
        REG_KERN_MID = 3'd3,
        REG_KERN_BOT = 3'd4
    } t_reg_idx;

    typedef logic [RGB_BITS-1:0] t_rgb;

    typedef struct packed {
        logic                cmd;
        logic [PIX_BITS-1:0] in_red;
        logic [PIX_BITS-1:0] in_green;
        logic [PIX_BITS-1:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [PIX_BITS-1:0] out_red;
        logic [PIX_BITS-1:0] out_green;
        logic [PIX_BITS-1:0] out_blue;
        logic                frame_last;
    } t_out_item;

    // which window borders fall outside the frame
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_pad;

    // one output pixel's worth of work: nine taps, index column*3+row
    typedef struct packed {
        t_rgb [NUM_TAPS-1:0] tap;
        logic                last;
    } t_task;

endpackage

`default_nettype wire

/* hw/rtl/rcz_ram.sv */
// generic single write port, single read port ram with registered read data
// uses rcz_pkg for default sizes
`default_nettype none

module rcz_ram
    import rcz_pkg::*;
#(
    parameter int WIDTH = 2 * RGB_BITS,
    parameter int DEPTH = DEF_MAX_WIDTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old content on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/rcz_front.sv */
// front end: position tracking, item classification, line memory and 3x3 window
// uses rcz_pkg and rcz_ram
`default_nettype none

module rcz_front
    import rcz_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [WW-1:0] i_width,
    input  logic [HW-1:0] i_height,
    input  logic          i_restart,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_in_item      i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output t_task         o_task
);

    // input position and output position counters
    logic [WW-1:0] r_col, n_col;
    logic [HW-1:0] r_row, n_row;
    logic [XW-1:0] r_ox, n_ox;
    logic [YW-1:0] r_oy, n_oy;

    // second stage, waits for the line memory read
    logic          r_f1_valid, n_f1_valid;
    t_rgb          r_f1_pix;
    logic          r_f1_rd;
    logic          r_f1_wr;
    logic          r_f1_has_out;
    logic          r_f1_last;
    logic [XW-1:0] r_f1_addr;
    t_pad          r_f1_pad;

    // left and centre columns, index column*3+row
    logic [2*KERN_DIM-1:0][RGB_BITS-1:0] r_win;

    logic [WW-1:0] w_m1;
    logic [HW-1:0] h_m1;
    logic          draining, ignore, rd_en, has_out;
    logic          col_end, ox_end, oy_end, last;
    logic          accept, take, f1_adv;
    t_pad          pad;
    t_rgb          pix, top_px, mid_px;
    logic [2*RGB_BITS-1:0]             ram_rdata;
    logic [KERN_DIM-1:0][RGB_BITS-1:0] right;

    always_comb begin
        w_m1     = i_width - WW'(1);
        h_m1     = i_height - HW'(1);
        draining = (r_row >= i_height);
        ignore   = !draining && (i_item.cmd == CMD_FLUSH);
        rd_en    = (r_col < i_width);
        has_out  = (r_row > HW'(1)) || ((r_row == HW'(1)) && (r_col != '0));
        col_end  = (r_col == w_m1);
        ox_end   = (WW'(r_ox) == w_m1);
        oy_end   = (HW'(r_oy) == h_m1);
        last     = has_out && ox_end && oy_end;

        pad.top    = (r_oy == '0);
        pad.bottom = oy_end;
        pad.left   = (r_ox == '0);
        pad.right  = ox_end;

        pix = draining ? '0 : {i_item.in_blue, i_item.in_green, i_item.in_red};

        f1_adv  = r_f1_valid && (!r_f1_has_out || i_ready);
        o_ready = !r_f1_valid || f1_adv;
        accept  = i_valid && o_ready;
        take    = accept && !ignore;
    end

    // position update
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_ox  = r_ox;
        n_oy  = r_oy;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
            n_ox  = '0;
            n_oy  = '0;
        end else if (take) begin
            if (last) begin
                n_col = '0;
                n_row = '0;
                n_ox  = '0;
                n_oy  = '0;
            end else begin
                if (!draining && col_end) begin
                    n_col = '0;
                    n_row = r_row + HW'(1);
                end else begin
                    n_col = r_col + WW'(1);
                end
                if (has_out) begin
                    if (ox_end) begin
                        n_ox = '0;
                        n_oy = r_oy + YW'(1);
                    end else begin
                        n_ox = r_ox + XW'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        n_f1_valid = r_f1_valid;
        if (take) begin
            n_f1_valid = 1'b1;
        end else if (f1_adv) begin
            n_f1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_ox       <= '0;
            r_oy       <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_ox       <= n_ox;
            r_oy       <= n_oy;
            r_f1_valid <= n_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_f1_pix     <= pix;
            r_f1_rd      <= rd_en;
            r_f1_wr      <= !draining;
            r_f1_has_out <= has_out;
            r_f1_last    <= last;
            r_f1_addr    <= r_col[XW-1:0];
            r_f1_pad     <= pad;
        end
    end

    // entry holds {centre row, row above}; written back in the cycle after its read
    rcz_ram #(
        .WIDTH (2 * RGB_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_f1_valid && r_f1_wr),
        .i_waddr (r_f1_addr),
        .i_wdata ({r_f1_pix, mid_px}),
        .i_re    (take && rd_en),
        .i_raddr (r_col[XW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        top_px = r_f1_rd ? ram_rdata[RGB_BITS-1:0] : '0;
        mid_px = r_f1_rd ? ram_rdata[2*RGB_BITS-1:RGB_BITS] : '0;
        right  = {r_f1_pix, mid_px, top_px};
    end

    // assemble the window, zeroing taps outside the frame
    always_comb begin
        t_rgb tap_v;
        logic zero;
        tap_v = '0;
        zero  = 1'b0;
        for (int t = 0; t < KERN_DIM; t++) begin
            for (int r = 0; r < KERN_DIM; r++) begin
                if (t == 0) begin
                    tap_v = r_win[r];
                end else if (t == 1) begin
                    tap_v = r_win[KERN_DIM + r];
                end else begin
                    tap_v = right[r];
                end
                zero = ((r == 0) && r_f1_pad.top) || ((r == KERN_DIM - 1) && r_f1_pad.bottom)
                    || ((t == 0) && r_f1_pad.left) || ((t == KERN_DIM - 1) && r_f1_pad.right);
                o_task.tap[t*KERN_DIM + r] = zero ? '0 : tap_v;
            end
        end
        o_task.last = r_f1_last;
    end

    assign o_valid = r_f1_valid && r_f1_has_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (f1_adv) begin
            r_win <= {right, r_win[2*KERN_DIM-1:KERN_DIM]};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rcz_queue.sv */
// small fifo of window tasks between the front end and the filter back end
// uses rcz_pkg
`default_nettype none

module rcz_queue
    import rcz_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_task i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_task o_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_task         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          push, pop;

    always_comb begin
        o_ready = (r_cnt != CW'(QUEUE_DEPTH));
        o_valid = (r_cnt != '0);
        push    = i_valid && o_ready;
        pop     = o_valid && i_ready;
        o_data  = r_mem[r_rp];

        n_wp = r_wp;
        n_rp = r_rp;
        if (push) begin
            n_wp = (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (pop) begin
            n_rp = (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        n_cnt = r_cnt + CW'(push) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rcz_back.sv */
// back end: 27 tap multipliers, row sums, final sum with clamp, output register
// uses rcz_pkg
`default_nettype none

module rcz_back
    import rcz_pkg::*;
#(
    parameter int COEF_BITS = DEF_COEF_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [KERN_DIM-1:0][CFG_KERN_BITS-1:0] i_kernel,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  t_task                                  i_task,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output t_out_item                              o_item
);

    localparam int PW = COEF_BITS + PIX_BITS + 1;
    localparam int SW = PW + 2;
    localparam int AW = SW + 2;
    localparam logic signed [AW-1:0] ACC_HI = AW'(PIX_MAX << FRAC_BITS);

    logic signed [PW-1:0] r_prod [NUM_CH][NUM_TAPS];
    logic signed [PW-1:0] n_prod [NUM_CH][NUM_TAPS];
    logic                 r_p_valid, r_p_last;

    logic signed [SW-1:0] r_rsum [NUM_CH][KERN_DIM];
    logic signed [SW-1:0] n_rsum [NUM_CH][KERN_DIM];
    logic                 r_s_valid, r_s_last;

    t_out_item r_out, n_out;
    logic      r_o_valid;

    logic rdy_p, rdy_s, rdy_o;

    always_comb begin
        rdy_o   = !r_o_valid || i_ready;
        rdy_s   = !r_s_valid || rdy_o;
        rdy_p   = !r_p_valid || rdy_s;
        o_ready = rdy_p;
    end

    // products: pixel is unsigned, coefficient signed q8.8
    always_comb begin
        logic signed [PW-1:0] a;
        logic signed [PW-1:0] b;
        a = '0;
        b = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            for (int t = 0; t < KERN_DIM; t++) begin
                for (int r = 0; r < KERN_DIM; r++) begin
                    a = PW'({1'b0, i_task.tap[t*KERN_DIM + r][c*PIX_BITS +: PIX_BITS]});
                    b = PW'($signed(i_kernel[r][t*COEF_BITS +: COEF_BITS]));
                    n_prod[c][t*KERN_DIM + r] = a * b;
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            for (int r = 0; r < KERN_DIM; r++) begin
                n_rsum[c][r] = SW'(r_prod[c][r]) + SW'(r_prod[c][KERN_DIM + r])
                             + SW'(r_prod[c][2*KERN_DIM + r]);
            end
        end
    end

    // final sum and clamp to the pixel range, fraction dropped
    always_comb begin
        logic signed [AW-1:0]         acc;
        logic [NUM_CH-1:0][PIX_BITS-1:0] ch;
        acc = '0;
        ch  = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            acc = AW'(r_rsum[c][0]) + AW'(r_rsum[c][1]) + AW'(r_rsum[c][2]);
            if (acc < 0) begin
                ch[c] = '0;
            end else if (acc >= ACC_HI) begin
                ch[c] = PIX_BITS'(PIX_MAX);
            end else begin
                ch[c] = acc[FRAC_BITS +: PIX_BITS];
            end
        end
        n_out.out_red    = ch[0];
        n_out.out_green  = ch[1];
        n_out.out_blue   = ch[2];
        n_out.frame_last = r_s_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (rdy_p) begin
                r_p_valid <= i_valid;
            end
            if (rdy_s) begin
                r_s_valid <= r_p_valid;
            end
            if (rdy_o) begin
                r_o_valid <= r_s_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy_p) begin
            r_prod   <= n_prod;
            r_p_last <= i_task.last;
        end
        if (r_p_valid && rdy_s) begin
            r_rsum   <= n_rsum;
            r_s_last <= r_p_last;
        end
        if (r_s_valid && rdy_o) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_o_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

/* hw/rtl/rgb_conv3x3_zero_pad.sv */
// top level of the rgb 3x3 convolution filter with zero padding
// uses rcz_pkg, rcz_front, rcz_queue and rcz_back
//
// usage
//   input channel: one rgb pixel per item in raster order, cmd selects pixel or
//   flush; after the frame's last pixel send image_width+1 flush items
//   output channel: one filtered rgb pixel per item, frame_last marks the
//   frame's final pixel; results trail the inputs by image_width+1 items
//   config channel: always ready, index picks the register, write only while
//   idle; a width or height write restarts the frame
// timing
//   one item per clock sustained while the output is not stalled, no bubbles between rows or frames
//   a result reaches the output after the item that releases it by way of:
//   line memory read, queue, multiplier stage, row sum stage, output register
// reset
//   synchronous, active low; geometry and kernel return to their defaults,
//   position counters and pipeline clear; the line memory is not cleared, its
//   stale entries only feed taps that padding zeroes
// stall
//   the output register holds while the receiver stalls, the two-entry queue
//   takes up the slack, then input ready drops
`default_nettype none

module rgb_conv3x3_zero_pad
    import rcz_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COEF_BITS  = DEF_COEF_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // pixel input
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_item,
    // filtered output
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_item,
    // register writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_KERN_BITS-1:0] i_cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    // reset geometry, saturated to the supported range
    localparam int RST_W = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
    localparam int RST_H = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;

    // geometry is held already clamped to its legal range
    logic [WW-1:0] r_width, n_width;
    logic [HW-1:0] r_height, n_height;
    logic [KERN_DIM-1:0][CFG_KERN_BITS-1:0] r_kernel, n_kernel;

    logic        cfg_we;
    logic        restart;
    logic [31:0] dim, w_sat, h_sat;

    // front to queue
    logic  fq_valid, fq_ready;
    t_task fq_task;
    // queue to back
    logic  qb_valid, qb_ready;
    t_task qb_task;

    assign o_cfg_ready = 1'b1;

    // saturate written geometry
    always_comb begin
        dim = 32'(i_cfg_data[CFG_DIM_BITS-1:0]);
        if (dim < 32'(MIN_WIDTH)) begin
            w_sat = 32'(MIN_WIDTH);
        end else if (dim > 32'(MAX_WIDTH)) begin
            w_sat = 32'(MAX_WIDTH);
        end else begin
            w_sat = dim;
        end
        if (dim < 32'(MIN_HEIGHT)) begin
            h_sat = 32'(MIN_HEIGHT);
        end else if (dim > 32'(MAX_HEIGHT)) begin
            h_sat = 32'(MAX_HEIGHT);
        end else begin
            h_sat = dim;
        end
    end

    // register decode; unused indexes write nothing
    always_comb begin
        cfg_we   = i_cfg_valid && o_cfg_ready;
        restart  = 1'b0;
        n_width  = r_width;
        n_height = r_height;
        n_kernel = r_kernel;
        if (cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH: begin
                    n_width = WW'(w_sat);
                    restart = 1'b1;
                end
                REG_HEIGHT: begin
                    n_height = HW'(h_sat);
                    restart  = 1'b1;
                end
                REG_KERN_TOP: begin
                    n_kernel[0] = i_cfg_data;
                end
                REG_KERN_MID: begin
                    n_kernel[1] = i_cfg_data;
                end
                REG_KERN_BOT: begin
                    n_kernel[2] = i_cfg_data;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WW'(RST_W);
            r_height    <= HW'(RST_H);
            r_kernel[0] <= KERN_TOP_RST;
            r_kernel[1] <= KERN_MID_RST;
            r_kernel[2] <= KERN_BOT_RST;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_kernel <= n_kernel;
        end
    end

    // position tracking, line memory, window assembly with padding
    rcz_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_restart (restart),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (i_in_item),
        .o_valid   (fq_valid),
        .i_ready   (fq_ready),
        .o_task    (fq_task)
    );

    // decouples the window builder from the arithmetic pipeline
    rcz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_data  (fq_task),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_data  (qb_task)
    );

    // multiply, accumulate, clamp, output register
    rcz_back #(
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_kernel (r_kernel),
        .i_valid  (qb_valid),
        .o_ready  (qb_ready),
        .i_task   (qb_task),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_item   (o_out_item)
    );

endmodule

`default_nettype wire

/* hw/rtl/rcz_chk.sv */
// port level checker for the rgb 3x3 convolution block, bound to the top level
// uses rcz_pkg and rgb_conv3x3_zero_pad_assert.svh
`default_nettype none
`include "rgb_conv3x3_zero_pad_assert.svh"

module rcz_chk
    import rcz_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // a stalled result stays put
    `RCZ_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "output changed while stalled")

    // reset empties the output register
    `RCZ_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // input back-pressure only follows a stalled output
    `RCZ_ASSERT(a_bp_cause, !o_in_ready |-> $past(o_out_valid && !i_out_ready), "input stalled without output stall")

endmodule

bind rgb_conv3x3_zero_pad rcz_chk u_rcz_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

/* sim/rgb_conv3x3_zero_pad_test.sv */
// self-checking testbench for the rgb 3x3 zero-padded convolution filter
// drives pixel frames and register writes, predicts every filtered pixel in sv
// depends on rcz_pkg and rgb_conv3x3_zero_pad
module rgb_conv3x3_zero_pad_test;
    import rcz_pkg::*;

    localparam int CB        = DEF_COEF_BITS;
    localparam int IN_BITS   = $bits(t_in_item);
    localparam int LONG_HOLD = 300;
    localparam int SETTLE    = 12;

    // clock, reset and block ports
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    t_in_item                 in_item = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    t_out_item                out_item;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = REG_WIDTH;
    logic [CFG_KERN_BITS-1:0] cfg_data = '0;

    // items waiting to be offered, filtered pixels still owed by the block
    t_in_item  pixel_feed[$];
    t_out_item filtered_pixels_due[$];
    t_out_item due_px;
    int        queued_total = 0;
    int        accepted_total = 0;
    int        fail_count = 0;

    // idle control shared between the scenario and the two channel processes
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int send_wait = 0;
    int recv_wait = 0;
    int hold_ticket = 0;
    int hold_served = 0;

    // shadow of the block's registers and pipeline position
    logic [11:0]              geo_width;
    logic [11:0]              geo_height;
    logic [CFG_KERN_BITS-1:0] kern_rows [KERN_DIM];
    t_rgb                     line_up  [DEF_MAX_WIDTH];
    t_rgb                     line_mid [DEF_MAX_WIDTH];
    t_rgb                     win [6];
    int unsigned              in_col;
    int unsigned              in_row;
    int unsigned              out_cnt;

    rgb_conv3x3_zero_pad dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // filter predictor
    // ---------------------------------------------------------------

    function automatic int unsigned frame_width();
        if (geo_width < 12'd2) return 2;
        if (geo_width > 12'(DEF_MAX_WIDTH)) return DEF_MAX_WIDTH;
        return 32'(geo_width);
    endfunction

    function automatic int unsigned frame_height();
        if (geo_height < 12'd1) return 1;
        if (geo_height > 12'(DEF_MAX_HEIGHT)) return DEF_MAX_HEIGHT;
        return 32'(geo_height);
    endfunction

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_cnt = 0;
    endfunction

    // power-up view: defaults in the registers, everything else zero
    function automatic void reset_shadow();
        geo_width    = 12'(WIDTH_RST);
        geo_height   = 12'(HEIGHT_RST);
        kern_rows[0] = KERN_TOP_RST;
        kern_rows[1] = KERN_MID_RST;
        kern_rows[2] = KERN_BOT_RST;
        for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            line_up[i]  = '0;
            line_mid[i] = '0;
        end
        for (int i = 0; i < 6; i++) win[i] = '0;
        restart_frame();
    endfunction

    function automatic void shadow_reg_write(t_reg_idx idx, logic [CFG_KERN_BITS-1:0] val);
        case (idx)
            REG_WIDTH: begin
                geo_width = val[11:0];
                restart_frame();
            end
            REG_HEIGHT: begin
                geo_height = val[11:0];
                restart_frame();
            end
            REG_KERN_TOP: kern_rows[0] = val;
            REG_KERN_MID: kern_rows[1] = val;
            REG_KERN_BOT: kern_rows[2] = val;
            default: ;
        endcase
    endfunction

    // one accepted item; queues the filtered pixel it releases, if any
    function automatic void predict_filtered_pixel(t_in_item it);
        int unsigned       w, h, ox, oy;
        bit                draining, released;
        t_rgb              pix, up, cen;
        t_rgb              col [9];
        longint unsigned   n;
        longint            acc;
        logic signed [CB-1:0] k;
        logic [7:0]        ch [3];
        t_out_item         res;
        w = frame_width();
        h = frame_height();
        draining = (in_row >= h);
        released = 1'b0;
        pix = '0;
        up  = '0;
        cen = '0;
        res = '0;
        // a flush before the frame is complete does nothing at all
        if (!draining && it.cmd == CMD_FLUSH) return;
        // once the frame is in, pixel data is dropped and the item drains
        if (!draining) pix = {it.in_blue, it.in_green, it.in_red};
        if (in_col < w) begin
            up  = line_up[in_col];
            cen = line_mid[in_col];
            if (!draining) begin
                line_up[in_col]  = cen;
                line_mid[in_col] = pix;
            end
        end
        for (int i = 0; i < 6; i++) col[i] = win[i];
        col[6] = up;
        col[7] = cen;
        col[8] = pix;
        n = longint'(in_row) * w + in_col;
        if (n >= longint'(w) + 1) begin
            ox = out_cnt % w;
            oy = out_cnt / w;
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int r = 0; r < 3; r++) begin
                    // zero padding above the first and below the last row
                    if (r == 0 && oy == 0) continue;
                    if (r == 2 && oy + 1 >= h) continue;
                    for (int t = 0; t < 3; t++) begin
                        // zero padding left of column 0 and right of the last
                        if (t == 0 && ox == 0) continue;
                        if (t == 2 && ox + 1 >= w) continue;
                        k = kern_rows[r][t*CB +: CB];
                        acc += longint'(col[t*3 + r][8*c +: 8]) * longint'(k);
                    end
                end
                if (acc < 0) ch[c] = 8'd0;
                else if (acc >= longint'(PIX_MAX) * 256) ch[c] = 8'(PIX_MAX);
                else ch[c] = 8'(acc >>> FRAC_BITS);
            end
            out_cnt++;
            res.out_red    = ch[0];
            res.out_green  = ch[1];
            res.out_blue   = ch[2];
            res.frame_last = (longint'(out_cnt) >= longint'(w) * h);
            filtered_pixels_due.push_back(res);
            released = 1'b1;
        end
        for (int i = 0; i < 6; i++) win[i] = col[i + 3];
        in_col++;
        if (!draining && in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        // the frame's final pixel resets the position for the next frame
        if (released && res.frame_last) restart_frame();
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int draw_gap();
        if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // kernel row styles: raw bits, small signed, box blur, full-scale, sharpen range
    function automatic logic [47:0] make_kernel_row(int style);
        logic [47:0] row;
        logic [15:0] c;
        row = rand48();
        if (style == 0) return row;
        for (int t = 0; t < 3; t++) begin
            case (style)
                1:       c = 16'($urandom_range(0, 128)) - 16'd64;
                2:       c = 16'd28;
                3:       c = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                default: c = 16'($urandom_range(0, 1024)) - 16'd512;
            endcase
            row[t*16 +: 16] = c;
        end
        return row;
    endfunction

    // pixel styles: any value, channel extremes, mid-gray band
    function automatic t_in_item make_item(int style, logic cmd);
        t_in_item it;
        it = IN_BITS'($urandom);
        it.cmd = cmd;
        if (style == 1) begin
            it.in_red   = {8{it.in_red[0]}};
            it.in_green = {8{it.in_green[0]}};
            it.in_blue  = {8{it.in_blue[0]}};
        end else if (style == 2) begin
            it.in_red   = 8'($urandom_range(100, 160));
            it.in_green = 8'($urandom_range(100, 160));
            it.in_blue  = 8'($urandom_range(100, 160));
        end
        return it;
    endfunction

    task automatic push_item(t_in_item it);
        pixel_feed.push_back(it);
        queued_total++;
    endtask

    task automatic push_pixel(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_in_item it;
        it.cmd      = cmd;
        it.in_red   = r;
        it.in_green = g;
        it.in_blue  = b;
        push_item(it);
    endtask

    // one frame in raster order plus its drain; stray flushes mixed in,
    // a few drain items carry pixel data, a short drain lets the next
    // frame's first item finish this one
    task automatic queue_frame(int w, int h, int style, bit short_drain);
        int ndrain;
        @(negedge clk);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 19) == 0) push_item(make_item(style, CMD_FLUSH));
            push_item(make_item(style, CMD_PIXEL));
        end
        ndrain = w + 1 - int'(short_drain);
        for (int i = 0; i < ndrain; i++)
            push_item(make_item(style, ($urandom_range(0, 7) == 0) ? CMD_PIXEL : CMD_FLUSH));
    endtask

    // register write over the config channel, shadow updated at the handshake
    task automatic write_reg(t_reg_idx idx, logic [CFG_KERN_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        shadow_reg_write(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // random upper bits ride along, only the low twelve count
    task automatic set_geometry(logic [11:0] w_raw, logic [11:0] h_raw);
        logic [47:0] v;
        v = rand48();
        v[11:0] = w_raw;
        write_reg(REG_WIDTH, v);
        v = rand48();
        v[11:0] = h_raw;
        write_reg(REG_HEIGHT, v);
    endtask

    task automatic set_kernel(int style_top, int style_mid, int style_bot);
        write_reg(REG_KERN_TOP, make_kernel_row(style_top));
        write_reg(REG_KERN_MID, make_kernel_row(style_mid));
        write_reg(REG_KERN_BOT, make_kernel_row(style_bot));
    endtask

    // everything offered is taken and every owed pixel is back, then a settling wait
    // for accepted items that release no pixel and may still be in the pipeline
    task automatic wait_idle();
        @(negedge clk);
        while (accepted_total != queued_total || filtered_pixels_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic report_mismatch(string what, int expv, int actv);
        fail_count++;
        $display("%0t: %s expected %0d actual %0d", $time, what, expv, actv);
    endtask

    // ---------------------------------------------------------------
    // input driver: offers queued items, holds them until taken
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            send_wait <= 0;
        end else begin
            if (in_valid && in_ready) begin
                predict_filtered_pixel(in_item);
                accepted_total++;
            end
            if (!in_valid || in_ready) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    in_valid  <= 1'b0;
                end else if (pixel_feed.size() > 0) begin
                    in_item  <= pixel_feed.pop_front();
                    in_valid <= 1'b1;
                    if (send_idle_on && $urandom_range(0, 2) == 0) send_wait <= draw_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // output receiver: random stalls, plus a long hold on request
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end else if (hold_served != hold_ticket) begin
            hold_served <= hold_ticket;
            recv_wait   <= LONG_HOLD;
            out_ready   <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            out_ready <= 1'b0;
        end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
            recv_wait <= draw_gap();
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // output checker: oldest owed pixel against each taken item
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (filtered_pixels_due.size() == 0) begin
                fail_count++;
                $display("%0t: item expected none actual %h", $time, out_item);
            end else begin
                due_px = filtered_pixels_due.pop_front();
                if (out_item.out_red !== due_px.out_red)
                    report_mismatch("out_red", int'(due_px.out_red), int'(out_item.out_red));
                if (out_item.out_green !== due_px.out_green)
                    report_mismatch("out_green", int'(due_px.out_green),
                                    int'(out_item.out_green));
                if (out_item.out_blue !== due_px.out_blue)
                    report_mismatch("out_blue", int'(due_px.out_blue), int'(out_item.out_blue));
                if (out_item.frame_last !== due_px.frame_last)
                    report_mismatch("frame_last", int'(due_px.frame_last),
                                    int'(out_item.frame_last));
            end
        end
    end

    // ---------------------------------------------------------------
    // scenario
    // ---------------------------------------------------------------
    initial begin
        int w, h, nframes, style, phase, random_items, base;
        reset_shadow();
        random_items = 0;
        phase = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // 3x2 frame through the reset kernel, a copy of the left neighbour: extremes,
        // a stray flush mid-frame and a pixel item used as drain
        set_geometry(12'd3, 12'd2);
        @(negedge clk);
        push_pixel(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
        push_pixel(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        push_pixel(CMD_PIXEL, 8'd255, 8'd0, 8'd255);
        push_pixel(CMD_FLUSH, 8'd17, 8'd34, 8'd51);
        push_pixel(CMD_PIXEL, 8'd0, 8'd255, 8'd0);
        push_pixel(CMD_PIXEL, 8'd128, 8'd1, 8'd254);
        push_pixel(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        push_pixel(CMD_FLUSH, 8'd0, 8'd0, 8'd0);
        push_pixel(CMD_PIXEL, 8'd200, 8'd100, 8'd50);
        push_pixel(CMD_FLUSH, 8'd255, 8'd255, 8'd255);
        push_pixel(CMD_FLUSH, 8'd0, 8'd0, 8'd0);
        wait_idle();

        // full-scale signed taps so both clamps trip; width 1 and height 0
        // saturate to the 2x1 minimum frame
        write_reg(REG_KERN_TOP, {16'h7fff, 16'h0080, 16'h8000});
        write_reg(REG_KERN_MID, {16'hffc0, 16'h0100, 16'h0040});
        write_reg(REG_KERN_BOT, {16'h8000, 16'h0000, 16'h7fff});
        set_geometry(12'd1, 12'd0);
        @(negedge clk);
        push_pixel(CMD_PIXEL, 8'd255, 8'd0, 8'd128);
        push_pixel(CMD_PIXEL, 8'd0, 8'd255, 8'd127);
        push_pixel(CMD_FLUSH, 8'd9, 8'd9, 8'd9);
        push_pixel(CMD_FLUSH, 8'd9, 8'd9, 8'd9);
        push_pixel(CMD_FLUSH, 8'd9, 8'd9, 8'd9);
        wait_idle();

        // geometry write in the middle of a frame starts a fresh one
        set_geometry(12'd2, 12'd3);
        @(negedge clk);
        push_pixel(CMD_PIXEL, 8'd10, 8'd20, 8'd30);
        push_pixel(CMD_PIXEL, 8'd250, 8'd240, 8'd230);
        push_pixel(CMD_PIXEL, 8'd1, 8'd2, 8'd3);
        push_pixel(CMD_PIXEL, 8'd128, 8'd64, 8'd32);
        wait_idle();
        write_reg(REG_HEIGHT, 48'd2);
        queue_frame(2, 2, 0, 1'b0);
        wait_idle();

        // random frames, a fresh geometry and kernel per phase
        while (random_items < 1200 || phase <= 2) begin
            if (phase == 2) begin
                w = 30;
                h = 10;
                nframes = 1;
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
            end else begin
                w = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 64) : $urandom_range(2, 10);
                h = $urandom_range(1, 6);
                nframes = $urandom_range(1, 3);
                send_idle_on = ($urandom_range(0, 3) != 0);
                recv_idle_on = ($urandom_range(0, 3) != 0);
            end
            // the low bound can be reached through saturation too
            set_geometry((w == 2 && $urandom_range(0, 1)) ? 12'($urandom_range(0, 1)) : 12'(w),
                         (h == 1 && $urandom_range(0, 1)) ? 12'd0 : 12'(h));
            style = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0)
                set_kernel($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4));
            else
                set_kernel(style, style, style);
            base = queued_total;
            for (int f = 0; f < nframes; f++) begin
                queue_frame(w, h, $urandom_range(0, 2),
                            (f != nframes - 1) && ($urandom_range(0, 7) == 0));
                random_items += w * h + w + 1;
            end
            if (phase == 2) begin
                // receiver stops for a long stretch while the sender keeps
                // offering, so the block backs up and drops input ready
                while (accepted_total < base + 40) @(negedge clk);
                hold_ticket++;
            end
            wait_idle();
            phase++;
        end

        // tall frame at the narrowest width, no idling
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        set_geometry(12'd0, 12'd384);
        set_kernel(1, 4, 1);
        queue_frame(2, 384, 0, 1'b0);
        wait_idle();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule
